// ===== design/librtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package librtr_pkg;

	// default sizing
	localparam int SEGMENTS_DEF    = 16;
	localparam int MAX_BUCKETS_DEF = 1024;

	// field widths fixed by the interface
	localparam int SEL_W      = 4;
	localparam int WORD_W     = 64;
	localparam int KEY_W      = 32;
	localparam int EP_W       = 32;
	localparam int SEG_CNT_W  = 5;
	localparam int BKT_CNT_W  = 11;
	localparam int BKT_IDX_W  = 10;
	localparam int CFG_DATA_W = 11;

	// multiply-accumulate datapath: sum is kept in units of 2^-48
	localparam int OPND_W = 33;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = 97;
	localparam int FRAC_W = 48;
	localparam int HALF_W = 32;

	// configuration register indexes
	localparam logic CFG_SEGMENT_COUNT = 1'b0;
	localparam logic CFG_BUCKET_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ENDPOINT  = 2'd0,
		KIND_SLOPE     = 2'd1,
		KIND_INTERCEPT = 2'd2,
		KIND_LOOKUP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH,
		ST_MUL_HI,
		ST_ACC_HI,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t                     kind;
		logic [SEL_W-1:0]          segment_select;
		logic signed [WORD_W-1:0]  table_word;
		logic signed [KEY_W-1:0]   search_key;
	} req_t;

	typedef struct packed {
		logic [SEL_W-1:0]     segment_found;
		logic [BKT_IDX_W-1:0] bucket_index;
	} rsp_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic load;     // accumulator takes the intercept
		logic add;      // accumulator adds the registered product
		logic shift_hi; // product being added is the upper-half one
		logic use_hi;   // multiplier takes the upper slope half
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ===== design/librtr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module librtr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [ADDR_W-1:0]     wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic [ADDR_W-1:0]     rd_addr,
	output logic      [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== design/librtr_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module librtr_mac (
	input  wire logic                                  clk,
	input  wire librtr_pkg::mac_ctrl_t                 ctrl,
	input  wire logic [librtr_pkg::WORD_W-1:0]         slope,
	input  wire logic [librtr_pkg::WORD_W-1:0]         icpt,
	input  wire logic signed [librtr_pkg::KEY_W-1:0]   key,
	output logic signed [librtr_pkg::ACC_W-1:0]        acc
);

	localparam int OPND_W = librtr_pkg::OPND_W;
	localparam int PROD_W = librtr_pkg::PROD_W;
	localparam int ACC_W  = librtr_pkg::ACC_W;
	localparam int HALF_W = librtr_pkg::HALF_W;
	localparam int WORD_W = librtr_pkg::WORD_W;

	logic signed [OPND_W-1:0] op_a;
	logic signed [PROD_W-1:0] a_ext;
	logic signed [PROD_W-1:0] b_ext;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_q;

	// slope half: low half unsigned, high half signed
	always_comb begin
		if (ctrl.use_hi) begin
			op_a = {slope[WORD_W-1], slope[WORD_W-1:HALF_W]};
		end else begin
			op_a = {1'b0, slope[HALF_W-1:0]};
		end
	end

	assign a_ext = {{(PROD_W-OPND_W){op_a[OPND_W-1]}}, op_a};
	assign b_ext = {{(PROD_W-librtr_pkg::KEY_W){key[librtr_pkg::KEY_W-1]}}, key};

	// one 33x33 signed multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= a_ext * b_ext;
	end

	// upper-half product is weighted by 2^32; its magnitude fits 65 bits
	always_comb begin
		if (ctrl.shift_hi) begin
			addend = {prod_s1[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
		end else begin
			addend = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	// accumulator: intercept in units of 2^-48, then the partial products
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= {{(ACC_W-WORD_W-HALF_W){icpt[WORD_W-1]}}, icpt, {HALF_W{1'b0}}};
		end else if (ctrl.add) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== design/learned_index_bucket_router_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Piecewise-linear learned-index router. A request with start high while busy is low is
// taken. Table writes (endpoint, slope, intercept) produce no result; busy stays low. A
// lookup raises busy for k binary-search steps (at most ceil(log2(n)), n = segments in
// use; 4 for sixteen segments), one endpoint-memory read per step, then during the
// intercept load and the low-half and high-half products of the single shared 33x33
// multiply-accumulate unit and during the clamp. The result appears on result for exactly one
// cycle with done high, in the first cycle with busy low; the receiver cannot stall it, so it
// must take every result as it comes. Configuration writes go straight into the registers
// and must only be issued while the block is idle. Table entries are undefined until written.
module learned_index_bucket_router_core #(
	parameter int SEGMENTS    = librtr_pkg::SEGMENTS_DEF,
	parameter int MAX_BUCKETS = librtr_pkg::MAX_BUCKETS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire librtr_pkg::req_t                     request,
	output logic                                      done,
	output librtr_pkg::rsp_t                          result,
	input  wire logic                                 cfg_wr_en,
	input  wire logic                                 cfg_addr,
	input  wire logic [librtr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int SEG_W     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int ACC_W     = librtr_pkg::ACC_W;
	localparam int FRAC_W    = librtr_pkg::FRAC_W;
	localparam int Q_W       = ACC_W - 1 - FRAC_W;
	localparam int BKT_CNT_W = librtr_pkg::BKT_CNT_W;
	localparam int SEG_CNT_W = librtr_pkg::SEG_CNT_W;

	librtr_pkg::state_t    state_q, state_d;
	librtr_pkg::mac_ctrl_t mac_ctrl;

	logic [SEG_CNT_W-1:0]            seg_cnt_q;
	logic [BKT_CNT_W-1:0]            bkt_cnt_q;
	logic [SEG_W-1:0]                last_seg;
	logic [BKT_CNT_W-1:0]            bc_eff;
	logic [SEG_W-1:0]                l_q, r_q, mid_q;
	logic [SEG_W-1:0]                l_d, r_d, mid_d;
	logic [SEG_W:0]                  mid_sum;
	logic signed [librtr_pkg::KEY_W-1:0] key_q;
	logic                            accept, take_lookup, sel_ok;
	logic                            ep_we, sl_we, ic_we;
	logic [librtr_pkg::EP_W-1:0]     ep_rdata;
	logic [librtr_pkg::WORD_W-1:0]   sl_rdata, ic_rdata;
	logic signed [ACC_W-1:0]         acc;
	logic [Q_W-1:0]                  q_val;
	logic [BKT_CNT_W-1:0]            bkt_full;
	logic                            finish;
	logic                            done_q;
	librtr_pkg::rsp_t                result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= SEG_CNT_W'(1);
			bkt_cnt_q <= BKT_CNT_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				librtr_pkg::CFG_SEGMENT_COUNT: seg_cnt_q <= cfg_wdata[SEG_CNT_W-1:0];
				librtr_pkg::CFG_BUCKET_COUNT:  bkt_cnt_q <= cfg_wdata[BKT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective segment and bucket counts
	always_comb begin
		if (seg_cnt_q == '0) begin
			last_seg = '0;
		end else if (32'(seg_cnt_q) > SEGMENTS) begin
			last_seg = SEG_W'(SEGMENTS - 1);
		end else begin
			last_seg = SEG_W'(seg_cnt_q - SEG_CNT_W'(1));
		end
		if (bkt_cnt_q == '0) begin
			bc_eff = BKT_CNT_W'(1);
		end else if (32'(bkt_cnt_q) > MAX_BUCKETS) begin
			bc_eff = BKT_CNT_W'(MAX_BUCKETS);
		end else begin
			bc_eff = bkt_cnt_q;
		end
	end

	// request decode and table writes
	assign accept      = start && !busy;
	assign take_lookup = accept && (request.kind == librtr_pkg::KIND_LOOKUP);
	assign sel_ok      = 32'(request.segment_select) < SEGMENTS;
	assign ep_we       = accept && sel_ok && (request.kind == librtr_pkg::KIND_ENDPOINT);
	assign sl_we       = accept && sel_ok && (request.kind == librtr_pkg::KIND_SLOPE);
	assign ic_we       = accept && sel_ok && (request.kind == librtr_pkg::KIND_INTERCEPT);

	// sequencer: search steps, then multiply-accumulate, then clamp
	always_comb begin
		state_d  = state_q;
		l_d      = l_q;
		r_d      = r_q;
		mac_ctrl = '0;
		finish   = 1'b0;
		unique case (state_q)
			librtr_pkg::ST_IDLE: begin
				if (take_lookup) begin
					l_d     = '0;
					r_d     = last_seg;
					state_d = (last_seg == '0) ? librtr_pkg::ST_FETCH : librtr_pkg::ST_SEARCH;
				end
			end
			librtr_pkg::ST_SEARCH: begin
				if ($signed(ep_rdata) >= key_q) begin
					r_d = mid_q;
				end else begin
					l_d = mid_q + SEG_W'(1);
				end
				state_d = (l_d < r_d) ? librtr_pkg::ST_SEARCH : librtr_pkg::ST_FETCH;
			end
			librtr_pkg::ST_FETCH: begin
				mac_ctrl.load = 1'b1;
				state_d       = librtr_pkg::ST_MUL_HI;
			end
			librtr_pkg::ST_MUL_HI: begin
				mac_ctrl.add    = 1'b1;
				mac_ctrl.use_hi = 1'b1;
				state_d         = librtr_pkg::ST_ACC_HI;
			end
			librtr_pkg::ST_ACC_HI: begin
				mac_ctrl.add      = 1'b1;
				mac_ctrl.shift_hi = 1'b1;
				state_d           = librtr_pkg::ST_DONE;
			end
			librtr_pkg::ST_DONE: begin
				finish  = 1'b1;
				state_d = librtr_pkg::ST_IDLE;
			end
			default: begin
				state_d = librtr_pkg::ST_IDLE;
			end
		endcase
	end

	// next probe address
	assign mid_sum = {1'b0, l_d} + {1'b0, r_d};
	assign mid_d   = mid_sum[SEG_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= librtr_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	// search bounds and key
	always_ff @(posedge clk) begin
		l_q   <= l_d;
		r_q   <= r_d;
		mid_q <= mid_d;
		if (take_lookup) begin
			key_q <= request.search_key;
		end
	end

	assign busy = (state_q != librtr_pkg::ST_IDLE);

	// model tables
	librtr_ram #(
		.WIDTH (librtr_pkg::EP_W),
		.DEPTH (SEGMENTS)
	) u_ep_ram (
		.clk     (clk),
		.wr_en   (ep_we),
		.wr_addr (SEG_W'(request.segment_select)),
		.wr_data (request.table_word[librtr_pkg::EP_W-1:0]),
		.rd_addr (mid_d),
		.rd_data (ep_rdata)
	);

	librtr_ram #(
		.WIDTH (librtr_pkg::WORD_W),
		.DEPTH (SEGMENTS)
	) u_slope_ram (
		.clk     (clk),
		.wr_en   (sl_we),
		.wr_addr (SEG_W'(request.segment_select)),
		.wr_data (request.table_word),
		.rd_addr (l_d),
		.rd_data (sl_rdata)
	);

	librtr_ram #(
		.WIDTH (librtr_pkg::WORD_W),
		.DEPTH (SEGMENTS)
	) u_icpt_ram (
		.clk     (clk),
		.wr_en   (ic_we),
		.wr_addr (SEG_W'(request.segment_select)),
		.wr_data (request.table_word),
		.rd_addr (l_d),
		.rd_data (ic_rdata)
	);

	// shared multiply-accumulate unit
	librtr_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.slope (sl_rdata),
		.icpt  (ic_rdata),
		.key   (key_q),
		.acc   (acc)
	);

	// truncate to whole buckets and clamp
	assign q_val = acc[ACC_W-2:FRAC_W];

	always_comb begin
		if (acc[ACC_W-1]) begin
			bkt_full = '0;
		end else if (q_val >= Q_W'(bc_eff)) begin
			bkt_full = bc_eff - BKT_CNT_W'(1);
		end else begin
			bkt_full = q_val[BKT_CNT_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.segment_found <= librtr_pkg::SEL_W'(l_q);
			result_q.bucket_index  <= bkt_full[librtr_pkg::BKT_IDX_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// a result only follows the clamp cycle
	a_done_after_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == librtr_pkg::ST_DONE))
		else $error("result strobe without a finished lookup");

	// an active search always has a nonempty range
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == librtr_pkg::ST_SEARCH) |-> (l_q < r_q))
		else $error("search entered with empty range");

	// the search converges to a single segment before the fetch
	a_fetch_converged: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == librtr_pkg::ST_FETCH) |-> (l_q == r_q))
		else $error("fetch with unresolved search bounds");

	// an accepted lookup makes the block busy
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_lookup |=> busy)
		else $error("lookup accepted but block not busy");
`endif

endmodule

`default_nettype wire
